/* src/imdm_pkg.sv */
`default_nettype none
package imdm_pkg;

   localparam int DataWidthDefault = 64;

   typedef enum logic [1:0] {
      CMD_MUL = 2'd0,
      CMD_DIV = 2'd1,
      CMD_REM = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   // Per-item control that travels alongside the datapath
   typedef struct packed {
      logic    valid;
      logic    ok;
      logic    sgn;
      logic    ovf;
      logic    neg;
      logic    a_neg;
      cmd_type cmd;
   } ctl_type;

endpackage
`default_nettype wire

/* src/imdm_mul.sv */
`default_nettype none
// Magnitude multiplier: four 32x32 partial products, registered, then summed.
// Advances one stage per enabled cycle; the summed product is registered as well.
module imdm_mul
   import imdm_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDefault
) (
   input  wire logic                      clock,
   input  wire logic                      enable,
   input  wire logic [DATA_WIDTH-1:0]     a_mag,
   input  wire logic [DATA_WIDTH-1:0]     b_mag,
   output logic      [2*DATA_WIDTH-1:0]   product
);

   localparam int HalfW = (DATA_WIDTH + 1) / 2;
   localparam int HiW   = DATA_WIDTH - HalfW;
   localparam int PW    = 2 * DATA_WIDTH;

   logic [2*HalfW-1:0]     p00_ff;
   logic [HalfW+HiW-1:0]   p01_ff;
   logic [HalfW+HiW-1:0]   p10_ff;
   logic [2*HiW-1:0]       p11_ff;
   logic [PW-1:0]          product_ff;
   logic [PW-1:0]          product_in;

   always_comb begin
      product_in = PW'(p00_ff)
                 + (PW'(p01_ff) << HalfW)
                 + (PW'(p10_ff) << HalfW)
                 + (PW'(p11_ff) << (2 * HalfW));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p00_ff     <= a_mag[HalfW-1:0] * b_mag[HalfW-1:0];
         p01_ff     <= a_mag[HalfW-1:0] * b_mag[DATA_WIDTH-1:HalfW];
         p10_ff     <= a_mag[DATA_WIDTH-1:HalfW] * b_mag[HalfW-1:0];
         p11_ff     <= a_mag[DATA_WIDTH-1:HalfW] * b_mag[DATA_WIDTH-1:HalfW];
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule
`default_nettype wire

/* src/imdm_div.sv */
`default_nettype none
// Pipelined restoring divider on magnitudes: one quotient bit per stage,
// DATA_WIDTH stages. One item per cycle while enable is high.
module imdm_div
   import imdm_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDefault
) (
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  wire logic [DATA_WIDTH-1:0]   dividend,
   input  wire logic [DATA_WIDTH-1:0]   divisor,
   output logic      [DATA_WIDTH-1:0]   quotient,
   output logic      [DATA_WIDTH-1:0]   remainder
);

   // Each stage: remainder, shifting dividend/quotient word, divisor
   logic [DATA_WIDTH-1:0] rem_ff [DATA_WIDTH];
   logic [DATA_WIDTH-1:0] quo_ff [DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dsr_ff [DATA_WIDTH];

   for (genvar s = 0; s < DATA_WIDTH; s++) begin : g_stage
      logic [DATA_WIDTH-1:0] rem_src;
      logic [DATA_WIDTH-1:0] quo_src;
      logic [DATA_WIDTH-1:0] dsr_src;
      logic [DATA_WIDTH:0]   trial;
      logic [DATA_WIDTH:0]   diff;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign quo_src = dividend;
         assign dsr_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign dsr_src = dsr_ff[s-1];
      end

      assign trial = {rem_src, quo_src[DATA_WIDTH-1]};
      assign diff  = trial - {1'b0, dsr_src};

      always_ff @(posedge clock) begin
         if (enable) begin
            dsr_ff[s] <= dsr_src;
            if (!diff[DATA_WIDTH]) begin
               rem_ff[s] <= diff[DATA_WIDTH-1:0];
               quo_ff[s] <= {quo_src[DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff[s] <= trial[DATA_WIDTH-1:0];
               quo_ff[s] <= {quo_src[DATA_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   assign quotient  = quo_ff[DATA_WIDTH-1];
   assign remainder = rem_ff[DATA_WIDTH-1];

endmodule
`default_nettype wire

/* src/int64_mul_div_mod_unit.sv */
`default_nettype none
// Channel | Dir | Handshake              | Payload
// req     | in  | req_tvalid/req_tready  | req_tdata: command, operands and flags
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: ok, value, signed, overflow
//
// The pipeline depth is set by the one-bit-per-stage divider; one transaction is taken
// every cycle while the output side takes results.
// The whole pipeline advances together; a stall at rsp holds every stage.
// Reset (synchronous) clears the valid bits only.
module int64_mul_div_mod_unit
   import imdm_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [1:0] command, [65:2] a_value, [66] a_signed, [67] a_overflow,
   // [68] a_is_integer, [132:69] b_value, [133] b_signed, [134] b_is_integer
   input  wire logic [135:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [0] ok, [64:1] result_value, [65] result_signed, [66] result_overflow
   output logic [71:0]        rsp_tdata
);

   localparam int W     = DATA_WIDTH;
   localparam int Depth = W + 2;  // stages after input register, to output

   logic              adv;
   logic [1:0]        cmd_raw;
   logic [W-1:0]      a_w;
   logic [W-1:0]      b_w;
   logic              sgn;
   logic              ints;

   // Stage 0: registered operands as magnitudes
   ctl_type           ctl0_ff, ctl0_in;
   logic [W-1:0]      am_ff, bm_ff, am_in, bm_in;

   ctl_type           ctl_ff [Depth];
   logic [W-1:0]      lo_ff [2];
   logic              hi_nz_ff [2];

   logic [2*W-1:0]    product;
   logic [W-1:0]      quotient;
   logic [W-1:0]      remainder;

   ctl_type           ctl_out;
   logic [W-1:0]      mag_lo;
   logic              mul_ovf;
   logic              div_ovf;
   logic [W-1:0]      res;
   logic [W-1:0]      half;

   assign adv        = !ctl_ff[Depth-1].valid || rsp_tready;
   assign req_tready = adv;

   assign cmd_raw = req_tdata[1:0];
   assign a_w     = req_tdata[2 +: W];
   assign b_w     = req_tdata[69 +: W];
   assign sgn     = req_tdata[66] | req_tdata[133];
   assign ints    = req_tdata[68] & req_tdata[134];

   always_comb begin
      ctl0_in.valid = req_tvalid;
      ctl0_in.cmd   = cmd_type'(cmd_raw);
      ctl0_in.sgn   = sgn;
      ctl0_in.ovf   = req_tdata[67];
      ctl0_in.a_neg = sgn & a_w[W-1];
      ctl0_in.neg   = sgn & (a_w[W-1] ^ b_w[W-1]);
      ctl0_in.ok    = ints && (cmd_raw != CMD_NOP)
                      && ((cmd_raw == CMD_MUL) || (b_w != '0));
      am_in = (sgn && a_w[W-1]) ? W'(-a_w) : a_w;
      bm_in = (sgn && b_w[W-1]) ? W'(-b_w) : b_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl0_ff <= ctl0_in;
         am_ff   <= am_in;
         bm_ff   <= bm_in;
      end
   end

   imdm_mul #(.DATA_WIDTH(W)) u_mul (
      .clock   (clock),
      .enable  (adv),
      .a_mag   (am_ff),
      .b_mag   (bm_ff),
      .product (product)
   );

   imdm_div #(.DATA_WIDTH(W)) u_div (
      .clock     (clock),
      .enable    (adv),
      .dividend  (am_ff),
      .divisor   ((bm_ff == '0) ? W'(1) : bm_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // Control line carried alongside the divider
   for (genvar s = 0; s < Depth; s++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[s] <= (s == 0) ? ctl0_ff : ctl_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // Product lands after stage index 1; carry it to the divider's exit
   logic [W-1:0] plo_ff [W-2];
   logic         phz_ff [W-2];
   for (genvar s = 0; s < W-2; s++) begin : g_prod
      always_ff @(posedge clock) begin
         if (adv) begin
            if (s == 0) begin
               plo_ff[s] <= product[W-1:0];
               phz_ff[s] <= product[2*W-1:W] != '0;
            end else begin
               plo_ff[s] <= plo_ff[(s == 0) ? 0 : s-1];
               phz_ff[s] <= phz_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   // Output stage: signs restored, overflow decided
   assign half = {1'b1, {(W-1){1'b0}}};
   assign ctl_out = ctl_ff[W-1];

   always_comb begin
      mag_lo  = plo_ff[W-3];
      mul_ovf = phz_ff[W-3]
                || (ctl_out.sgn && (mag_lo > (ctl_out.neg ? half : half - W'(1))));
      div_ovf = ctl_out.sgn && !ctl_out.neg && quotient[W-1];
      case (ctl_out.cmd)
         CMD_MUL: res = ctl_out.neg ? W'(-mag_lo) : mag_lo;
         CMD_DIV: res = ctl_out.neg ? W'(-quotient) : quotient;
         CMD_REM: res = ctl_out.a_neg ? W'(-remainder) : remainder;
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff[0]    <= res;
         hi_nz_ff[0] <= ctl_out.ovf
                        || (ctl_out.cmd == CMD_MUL && mul_ovf)
                        || (ctl_out.cmd == CMD_DIV && div_ovf);
         lo_ff[1]    <= lo_ff[0];
         hi_nz_ff[1] <= hi_nz_ff[0];
      end
   end

   ctl_type fin;
   assign fin        = ctl_ff[Depth-1];
   assign rsp_tvalid = fin.valid;
   always_comb begin
      rsp_tdata       = '0;
      rsp_tdata[0]    = fin.ok;
      rsp_tdata[1 +: W] = fin.ok ? lo_ff[1] : '0;
      rsp_tdata[65]   = fin.ok & fin.sgn;
      rsp_tdata[66]   = fin.ok & hi_nz_ff[1];
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");
   a_notok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[66:1] == '0)
      else $error("failed result carries data");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
module testbench;
   import imdm_pkg::*;

   localparam int Latency  = 67;
   localparam int WdLimit  = 4000;
   localparam int NumRand  = 500;

   typedef struct packed {
      logic        ok;
      logic [63:0] value;
      logic        sgn;
      logic        ovf;
   } outcome_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [135:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [71:0]   rsp_tdata;
   int            errors = 0;
   int            idle_cycles = 0;

   int64_mul_div_mod_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic logic [63:0] mag(input logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic outcome_type arith(input logic [135:0] d);
      cmd_type      cmd;
      logic [63:0]  a, b, lo, hi, ma, mb, q, r;
      logic [127:0] p;
      logic         sgn, ovf, neg;
      outcome_type  o;
      cmd = cmd_type'(d[1:0]);
      a = d[65:2];
      b = d[132:69];
      sgn = d[66] | d[133];
      ovf = d[67];
      o = '0;
      if (!(d[68] & d[134]) || cmd == CMD_NOP) return o;
      if (cmd != CMD_MUL && b == 0) return o;
      ma = sgn ? mag(a) : a;
      mb = sgn ? mag(b) : b;
      neg = sgn & (a[63] ^ b[63]);
      case (cmd)
         CMD_MUL: begin
            p = {64'd0, ma} * {64'd0, mb};
            hi = p[127:64];
            lo = p[63:0];
            if (sgn) begin
               if (hi != 0 || lo > (neg ? 64'h8000_0000_0000_0000
                                        : 64'h7fff_ffff_ffff_ffff)) ovf = 1;
               o.value = neg ? -lo : lo;
            end else begin
               if (hi != 0) ovf = 1;
               o.value = lo;
            end
         end
         CMD_DIV: begin
            q = ma / mb;
            if (sgn && !neg && q[63]) ovf = 1;
            o.value = neg ? -q : q;
         end
         default: begin
            r = ma % mb;
            o.value = (sgn && a[63]) ? -r : r;
         end
      endcase
      o.ok = 1;
      o.sgn = sgn;
      o.ovf = ovf;
      return o;
   endfunction

   class ResultBoard;
      outcome_type pending[$];
      function void note(input logic [135:0] d);
         pending.push_back(arith(d));
      endfunction
      task check(input logic [71:0] t);
         outcome_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", t));
            return;
         end
         e = pending.pop_front();
         if (t[0] !== e.ok) report($sformatf("ok %b exp %b", t[0], e.ok));
         if (t[64:1] !== e.value)
            report($sformatf("value %h exp %h", t[64:1], e.value));
         if (t[65] !== e.sgn) report($sformatf("signed %b exp %b", t[65], e.sgn));
         if (t[66] !== e.ovf) report($sformatf("ovf %b exp %b", t[66], e.ovf));
      endtask
   endclass

   ResultBoard board = new();

   // receiver stall pattern: alternate stretches of full rate and random stalls
   int rx_phase = 0;
   always @(negedge clock) begin
      rx_phase <= (rx_phase + 1) % 300;
      if (reset) rsp_tready <= 0;
      else if (rx_phase < 100) rsp_tready <= 1;
      else if (rx_phase < 200) rsp_tready <= ($urandom_range(3) != 0);
      else rsp_tready <= ($urandom_range(3) == 0);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (!req_tvalid && board.pending.size() == 0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WdLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   int burst_left = 0;

   // send one transaction, keeping valid high inside a burst
   task automatic send(input logic [135:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(20, 1);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] pick_val();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return 64'd1;
         2: return '1;
         3: return 64'h8000_0000_0000_0000;
         4: return 64'h7fff_ffff_ffff_ffff;
         5: return {$urandom, $urandom} >> $urandom_range(63);
         6: return 64'(signed'($urandom_range(200)) - 100);
         7: return {32'd0, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [135:0] pack(input cmd_type c, input logic [63:0] a,
      input logic as, ao, ai, input logic [63:0] b, input logic bs, bi);
      return {1'b0, bi, bs, b, ai, ao, as, a, c};
   endfunction

   localparam logic [63:0] Min = 64'h8000_0000_0000_0000;
   localparam logic [63:0] Max = 64'h7fff_ffff_ffff_ffff;

   initial begin
      logic [1:0] c;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed
      send(pack(CMD_MUL, Max, 1, 0, 1, 64'd2, 1, 1));
      send(pack(CMD_MUL, Min, 1, 0, 1, '1, 0, 1));
      send(pack(CMD_MUL, '1, 0, 0, 1, '1, 0, 1));
      send(pack(CMD_MUL, Min, 1, 0, 1, 64'd1, 1, 1));
      send(pack(CMD_MUL, 64'h4000_0000_0000_0000, 1, 0, 1, '1, 1, 1));
      send(pack(CMD_MUL, 64'h4000_0000_0000_0000, 1, 0, 1, 64'd2, 1, 1));
      send(pack(CMD_MUL, 64'd3, 0, 1, 1, 64'd5, 0, 1));
      send(pack(CMD_DIV, Min, 1, 0, 1, '1, 1, 1));
      send(pack(CMD_REM, Min, 1, 0, 1, '1, 1, 1));
      send(pack(CMD_DIV, 64'd7, 1, 0, 1, 64'd0, 1, 1));
      send(pack(CMD_REM, 64'd7, 0, 0, 1, 64'd0, 0, 1));
      send(pack(CMD_DIV, -64'd7, 1, 0, 1, 64'd2, 0, 1));
      send(pack(CMD_REM, -64'd7, 1, 1, 1, 64'd2, 1, 1));
      send(pack(CMD_REM, 64'd7, 1, 0, 1, -64'd2, 1, 1));
      send(pack(CMD_DIV, '1, 0, 0, 1, 64'd3, 0, 1));
      send(pack(CMD_REM, '1, 0, 1, 1, Min, 0, 1));
      send(pack(CMD_MUL, 64'd5, 1, 1, 0, 64'd5, 1, 1));
      send(pack(CMD_DIV, 64'd5, 1, 1, 1, 64'd5, 1, 0));
      send(pack(CMD_NOP, 64'd5, 1, 1, 1, 64'd5, 1, 1));
      // random
      repeat (NumRand) begin
         c = ($urandom_range(19) == 0) ? CMD_NOP : 2'($urandom_range(2));
         send(pack(cmd_type'(c), pick_val(), 1'($urandom), 1'($urandom),
                   ($urandom_range(15) != 0), pick_val(), 1'($urandom),
                   ($urandom_range(15) != 0)));
      end
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      if (errors == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
